FILE: src/dics_pkg.sv
`timescale 1ns / 1ps

package dics_pkg;

    // Field widths of one request and one result.
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int WGT_W  = 16;
    localparam int FRAC_W = 32;
    localparam int CUM_W  = 22;
    localparam int TS_W   = 7;
    localparam int PROD_W = FRAC_W + CUM_W;

    localparam int MAX_ENTRIES_DEF = 64;

    // Each cell of the search chain holds this many table entries.
    localparam int CELL_ENTRIES = 8;
    localparam int CELL_SEL_W   = 3;

    localparam logic [CUM_W-1:0] CUM_MAX  = '1;
    localparam logic [TS_W-1:0]  TS_RESET = 7'd1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic STATUS_MATCH    = 1'b0;
    localparam logic STATUS_NO_MATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_MULT,
        ST_LAUNCH,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Token that moves one cell down the chain per cycle. In a fetch pass,
    // cum picks up the cumulative weight of the last entry in use. In a
    // search pass, cum carries the cumulative weight of the entry just
    // before the receiving cell.
    typedef struct packed {
        logic              valid;
        logic              fetch;
        logic [CUM_W-1:0]  tgt_hi;
        logic              tgt_lo_zero;
        logic [CUM_W-1:0]  cum;
        logic              found;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  index;
    } dics_tok_t;

    // Table write broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
        logic [CUM_W-1:0]  cum;
    } dics_wr_t;

endpackage

FILE: src/dics_if.sv
`timescale 1ns / 1ps

interface dics_req_if;
    import dics_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]  entry_value;
    logic [WGT_W-1:0]         entry_weight;
    logic [FRAC_W-1:0]        uniform_fraction;

    modport source (output valid, output req_type, output entry_index,
                    output entry_value, output entry_weight, output uniform_fraction,
                    input ready);
    modport sink (input valid, input req_type, input entry_index,
                  input entry_value, input entry_weight, input uniform_fraction,
                  output ready);
endinterface

interface dics_rsp_if;
    import dics_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  sample_value;
    logic [IDX_W-1:0]         sample_index;
    logic                     status;

    modport source (output valid, output sample_value, output sample_index,
                    output status, input ready);
    modport sink (input valid, input sample_value, input sample_index,
                  input status, output ready);
endinterface

interface dics_cfg_if;
    import dics_pkg::*;
    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  table_size;

    modport source (output valid, output table_size, input ready);
    modport sink (input valid, input table_size, output ready);
endinterface

FILE: src/dics_cell.sv
`timescale 1ns / 1ps

module dics_cell
    import dics_pkg::*;
#(
    parameter int CNT_W   = 7,
    parameter int CELL_ID = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dics_wr_t          wr,
    input  logic [CNT_W-1:0]  n_eff,
    input  dics_tok_t         tin,
    output dics_tok_t         tout
);

    localparam int BASE = CELL_ID * CELL_ENTRIES;

    logic [VAL_W-1:0] val_reg [CELL_ENTRIES];
    logic [CUM_W-1:0] cum_reg [CELL_ENTRIES];

    logic             valid_reg;
    logic             valid_next;
    dics_tok_t        pay_reg;
    dics_tok_t        pay_next;

    logic [CNT_W-1:0] wr_pos;
    logic             wr_here;
    logic [CNT_W-1:0] last_pos;
    logic             last_here;

    function automatic logic cum_ge(input logic [CUM_W-1:0] c,
                                    input logic [CUM_W-1:0] hi,
                                    input logic lo_zero);
        // c * 2^32 >= {hi, lo}, where lo_zero tells whether lo is zero.
        return (c > hi) || ((c == hi) && lo_zero);
    endfunction

    assign wr_pos    = CNT_W'(wr.idx);
    assign wr_here   = wr.en &&
                       (wr_pos[CNT_W-1:CELL_SEL_W] == (CNT_W-CELL_SEL_W)'(CELL_ID));
    assign last_pos  = n_eff - CNT_W'(1);
    assign last_here = (n_eff != '0) &&
                       (last_pos[CNT_W-1:CELL_SEL_W] == (CNT_W-CELL_SEL_W)'(CELL_ID));

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            val_reg[wr.idx[CELL_SEL_W-1:0]] <= wr.value;
            cum_reg[wr.idx[CELL_SEL_W-1:0]] <= wr.cum;
        end
    end

    always_comb
    begin
        logic [CUM_W-1:0] prev;
        logic             active;
        logic             hit;
        pay_next = tin;
        prev     = tin.cum;
        active   = 1'b0;
        hit      = 1'b0;
        if (tin.fetch)
        begin
            if (last_here)
            begin
                pay_next.cum = cum_reg[last_pos[CELL_SEL_W-1:0]];
            end
        end
        else
        begin
            // First entry in cell order whose sum reaches the target while the
            // sum before it does not.
            for (int j = 0; j < CELL_ENTRIES; j++)
            begin
                active = (CNT_W'(BASE) + CNT_W'(j)) < n_eff;
                hit    = active && cum_ge(cum_reg[j], tin.tgt_hi, tin.tgt_lo_zero) &&
                         !cum_ge(prev, tin.tgt_hi, tin.tgt_lo_zero);
                if (hit && !pay_next.found)
                begin
                    pay_next.found = 1'b1;
                    pay_next.value = val_reg[j];
                    pay_next.index = IDX_W'(BASE + j);
                end
                prev = cum_reg[j];
            end
            pay_next.cum = cum_reg[CELL_ENTRIES-1];
        end
    end

    assign valid_next = tin.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

    always_comb
    begin
        tout       = pay_reg;
        tout.valid = valid_reg;
    end

endmodule

FILE: src/dics_ctrl.sv
`timescale 1ns / 1ps

module dics_ctrl
    import dics_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CNT_W       = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [VAL_W-1:0]  entry_value,
    input  logic [WGT_W-1:0]         entry_weight,
    input  logic [FRAC_W-1:0]        uniform_fraction,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TS_W-1:0]          cfg_table_size,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [VAL_W-1:0]  sample_value,
    output logic [IDX_W-1:0]         sample_index,
    output logic                     status,
    output dics_wr_t                 wr,
    output logic [CNT_W-1:0]         n_eff,
    output dics_tok_t                tok_in,
    input  dics_tok_t                tok_out
);

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_ENTRIES);

    state_t              state_reg;
    state_t              state_next;
    logic [TS_W-1:0]     table_size_reg;
    logic [CUM_W-1:0]    running_total_reg;
    logic [CUM_W-1:0]    running_total_next;
    logic [CUM_W-1:0]    total_reg;
    logic                stale_reg;
    logic [FRAC_W-1:0]   r_reg;
    logic [PROD_W-1:0]   target_reg;
    logic [VAL_W-1:0]    res_value_reg;
    logic [IDX_W-1:0]    res_index_reg;
    logic                res_status_reg;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic                out_status_reg;

    logic                in_fire;
    logic                load_fire;
    logic                sample_fire;
    logic                cfg_fire;
    logic                idx_ok;
    logic [CNT_W-1:0]    ts_ext;
    logic [CUM_W:0]      sum_wide;
    logic                no_match;
    logic                out_load;

    assign ts_ext      = CNT_W'(table_size_reg);
    assign n_eff       = (ts_ext > MAX_N) ? MAX_N : ts_ext;
    assign in_fire     = in_valid && in_ready;
    assign load_fire   = in_fire && (req_type == REQ_LOAD);
    assign sample_fire = in_fire && (req_type == REQ_SAMPLE);
    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign idx_ok      = CNT_W'(entry_index) < MAX_N;
    assign no_match    = (r_reg == '0) || (total_reg == '0);
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Entry zero restarts the running sum; the sum saturates.
    assign sum_wide = ((entry_index == '0) ? '0 : {1'b0, running_total_reg}) +
                      (CUM_W+1)'(entry_weight);
    assign running_total_next = (sum_wide > {1'b0, CUM_MAX}) ? CUM_MAX
                                                             : sum_wide[CUM_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    if (n_eff == '0)
                        state_next = ST_DONE;
                    else if (stale_reg)
                        state_next = ST_FETCH;
                    else
                        state_next = ST_MULT;
                end
            end
            ST_FETCH:      state_next = ST_FETCH_WAIT;
            ST_FETCH_WAIT:
            begin
                if (tok_out.valid)
                    state_next = ST_MULT;
            end
            ST_MULT:       state_next = ST_LAUNCH;
            ST_LAUNCH:     state_next = no_match ? ST_DONE : ST_SEARCH;
            ST_SEARCH:
            begin
                if (tok_out.valid)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready           = (state_reg == ST_IDLE);
        tok_in             = '0;
        tok_in.valid       = (state_reg == ST_FETCH) ||
                             ((state_reg == ST_LAUNCH) && !no_match);
        tok_in.fetch       = (state_reg == ST_FETCH);
        tok_in.tgt_hi      = target_reg[PROD_W-1:FRAC_W];
        tok_in.tgt_lo_zero = (target_reg[FRAC_W-1:0] == '0);
        wr.en              = load_fire && idx_ok;
        wr.idx             = entry_index;
        wr.value           = entry_value;
        wr.cum             = running_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            table_size_reg    <= TS_RESET;
            running_total_reg <= '0;
            total_reg         <= '0;
            stale_reg         <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                table_size_reg <= cfg_table_size;
                stale_reg      <= 1'b1;
            end
            else if ((state_reg == ST_FETCH_WAIT) && tok_out.valid)
            begin
                total_reg <= tok_out.cum;
                stale_reg <= 1'b0;
            end
            else if (load_fire && idx_ok)
            begin
                running_total_reg <= running_total_next;
                if ((n_eff != '0) && (CNT_W'(entry_index) == n_eff - CNT_W'(1)))
                    total_reg <= running_total_next;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            r_reg          <= uniform_fraction;
            res_value_reg  <= '0;
            res_index_reg  <= '0;
            res_status_reg <= STATUS_NO_MATCH;
        end
        if (state_reg == ST_MULT)
            target_reg <= PROD_W'(r_reg) * PROD_W'(total_reg);
        if ((state_reg == ST_SEARCH) && tok_out.valid && tok_out.found)
        begin
            res_value_reg  <= tok_out.value;
            res_index_reg  <= tok_out.index;
            res_status_reg <= STATUS_MATCH;
        end
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = $signed(out_value_reg);
    assign sample_index = out_index_reg;
    assign status       = out_status_reg;

endmodule

FILE: src/discrete_inverse_cdf_sampler_top.sv
`timescale 1ns / 1ps
// Loads can follow back to back and give no result. A sample passes MULT, LAUNCH, SEARCH
// and DONE; in SEARCH the token walks the chain of NCELLS = ceil(MAX_ENTRIES / 8) cells,
// which a zero fraction or total weight skips; a zero table_size goes straight to DONE.
// The result shows when DONE loads the output register; the next request can be taken in
// that same cycle. The first sample after reset or a table_size write first fetches the
// total weight in FETCH and FETCH_WAIT. Reset clears control state, sets table_size to 1.
module discrete_inverse_cdf_sampler_top
    import dics_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dics_req_if.sink    req,
    dics_rsp_if.source  rsp,
    dics_cfg_if.sink    cfg
);

    localparam int NCELLS  = (MAX_ENTRIES + CELL_ENTRIES - 1) / CELL_ENTRIES;
    localparam int CHAIN_W = $clog2(NCELLS * CELL_ENTRIES + 1);
    localparam int CNT_W   = (CHAIN_W > TS_W) ? CHAIN_W : TS_W;

    dics_wr_t          wr;
    logic [CNT_W-1:0]  n_eff;
    dics_tok_t         tok [NCELLS+1];

    dics_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (req.valid),
        .in_ready         (req.ready),
        .req_type         (req.req_type),
        .entry_index      (req.entry_index),
        .entry_value      (req.entry_value),
        .entry_weight     (req.entry_weight),
        .uniform_fraction (req.uniform_fraction),
        .cfg_valid        (cfg.valid),
        .cfg_ready        (cfg.ready),
        .cfg_table_size   (cfg.table_size),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .sample_value     (rsp.sample_value),
        .sample_index     (rsp.sample_index),
        .status           (rsp.status),
        .wr               (wr),
        .n_eff            (n_eff),
        .tok_in           (tok[0]),
        .tok_out          (tok[NCELLS])
    );

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        dics_cell #(
            .CNT_W   (CNT_W),
            .CELL_ID (g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .wr    (wr),
            .n_eff (n_eff),
            .tin   (tok[g]),
            .tout  (tok[g+1])
        );
    end

endmodule
